// ===== hdl/binomial_pyramid_reduce_2x_macros.svh =====
// Assertion macros for the port-level checker of the pyramid reducer.
`ifndef BINOMIAL_PYRAMID_REDUCE_2X_MACROS_SVH
`define BINOMIAL_PYRAMID_REDUCE_2X_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BPR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bpr_pkg.sv =====
// Shared types and constants of the 2x binomial pyramid reducer.
`default_nettype none
package bpr_pkg;

  localparam int unsigned MaxOutWidth  = 1024;
  localparam int unsigned MaxOutHeight = 4096;
  localparam int unsigned LineRows     = 5;
  localparam int unsigned RowSpan      = 2 * MaxOutWidth;
  localparam int unsigned ColW         = $clog2(RowSpan);
  localparam int unsigned RowW         = $clog2(2 * MaxOutHeight);
  localparam int unsigned WidthW       = 11;
  localparam int unsigned HeightW      = 13;
  localparam int unsigned SlotW        = $clog2(LineRows);
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned PixW         = 8;
  localparam int unsigned VSumW        = 11;
  localparam int unsigned HSumW        = 14;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrW        = $clog2(QDepth);

  typedef enum logic [CfgIdxW-1:0] {
    REG_OUT_WIDTH  = 2'd0,
    REG_OUT_HEIGHT = 2'd1
  } cfg_reg_e;

  // Which input rows feed the vertical taps of the current row.
  typedef enum logic [1:0] {
    VC_NORM    = 2'd0,
    VC_TOP     = 2'd1,
    VC_PRELAST = 2'd2,
    VC_LAST    = 2'd3
  } vcase_e;

  typedef enum logic [1:0] {
    HC_NORM  = 2'd0,
    HC_LEFT  = 2'd1,
    HC_RIGHT = 2'd2
  } hcase_e;

  typedef struct packed {
    logic [PixW-1:0]  pixel;
    logic [ColW-1:0]  col;
    logic [SlotW-1:0] slot;
    vcase_e           vcase;
    hcase_e           hcase;
    logic             emit;
    logic             row_end;
    logic             frame_end;
  } desc_t;

  // Slot holding input row r-d, given the slot of row r.
  function automatic logic [SlotW-1:0] prev_slot(input logic [SlotW-1:0] slot,
                                                 input logic [SlotW-1:0] d);
    logic [SlotW:0] s;
    s = {1'b0, slot} + (SlotW+1)'(LineRows) - {1'b0, d};
    if (s >= (SlotW+1)'(LineRows)) begin
      s = s - (SlotW+1)'(LineRows);
    end
    return s[SlotW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bpr_if.sv =====
// Stream interfaces of the pyramid reducer: pixel input and reduced output.
`default_nettype none
interface bpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/binomial_pyramid_reduce_2x.sv =====
// Top level of the 2x binomial pyramid reducer.
// Usage:
//   in_i takes 8-bit pixels of a 2W x 2H frame in raster order, one request
//   per cycle with valid/ready. out_o gives the W x H reduced frame, each
//   pixel the [1 3 3 1] x [1 3 3 1] weighted sum rounded and divided by 64,
//   with row_end on the last pixel of a row and frame_end on the last pixel
//   of the frame. Most input pixels give no output.
//   Config: cfg_we_i with cfg_idx_i 0 sets W, 1 sets H; a write restarts the
//   frame at row 0, column 0. Write only while the block is idle.
// Timing:
//   One pixel per cycle sustained while out_o is not held. The input pixel
//   completing a result goes through the queue and these registered steps:
//   queue pop with line store read, vertical sum, horizontal sum into the output reg.
//   The line store is five 2048-byte banks, one read and one write per cycle.
// Reset: counters return to the frame start, W = 320, H = 240. Line store
//   content is not cleared; only rows written in the current frame are read.
// Stall: while out_o is held, the back end freezes and a 4-entry queue keeps
//   taking input; in_i.ready drops once it is full.
`default_nettype none
module binomial_pyramid_reduce_2x (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bpr_pkg::CfgDataW-1:0] cfg_data_i,
  bpr_in_if.sink                            in_i,
  bpr_out_if.source                         out_o
);
  import bpr_pkg::*;

  desc_t push_desc, pop_desc;
  logic  push, q_full, q_valid, pop;

  bpr_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .desc_o   (push_desc)
  );

  bpr_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .desc_o  (pop_desc)
  );

  bpr_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_desc_i  (pop_desc),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

// ===== hdl/bpr_front.sv =====
// Front end: config registers, raster counters and per-pixel classification.
`default_nettype none
module bpr_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bpr_pkg::CfgDataW-1:0] cfg_data_i,
  bpr_in_if.sink                            in_i,
  input  wire logic                         q_full_i,
  output logic                              push_o,
  output bpr_pkg::desc_t                    desc_o
);
  import bpr_pkg::*;

  logic [WidthW-1:0]  cfg_w_q, cfg_w_d;
  logic [HeightW-1:0] cfg_h_q, cfg_h_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [WidthW-1:0]  eff_w;
  logic [HeightW-1:0] eff_h;
  logic [ColW:0]      two_w;
  logic [RowW:0]      two_h;
  logic [RowW:0]      row_x;
  logic               col_last, row_last, accept;
  logic               v_norm, v_top, v_pre, v_last, h_norm, h_left;

  always_comb begin
    eff_w = cfg_w_q;
    if (cfg_w_q < WidthW'(3)) begin
      eff_w = WidthW'(3);
    end else if (cfg_w_q > WidthW'(MaxOutWidth)) begin
      eff_w = WidthW'(MaxOutWidth);
    end
    eff_h = cfg_h_q;
    if (cfg_h_q < HeightW'(3)) begin
      eff_h = HeightW'(3);
    end else if (cfg_h_q > HeightW'(MaxOutHeight)) begin
      eff_h = HeightW'(MaxOutHeight);
    end
  end

  assign two_w    = {eff_w, 1'b0};
  assign two_h    = {eff_h, 1'b0};
  assign row_x    = {1'b0, row_q};
  assign col_last = ({1'b0, col_q} == two_w - (ColW+1)'(1));
  assign row_last = (row_x == two_h - (RowW+1)'(1));

  assign v_last = row_last;
  assign v_pre  = (row_x == two_h - (RowW+1)'(3));
  assign v_top  = (row_q == RowW'(2));
  assign v_norm = !row_q[0] && (row_q >= RowW'(2)) && (row_x < two_h - (RowW+1)'(2));
  assign h_left = (col_q == ColW'(2));
  assign h_norm = !col_q[0] && (col_q >= ColW'(2));

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign push_o     = accept;

  always_comb begin
    desc_o.pixel     = in_i.pixel_in;
    desc_o.col       = col_q;
    desc_o.slot      = slot_q;
    desc_o.vcase     = VC_NORM;
    if (v_last) begin
      desc_o.vcase = VC_LAST;
    end else if (v_pre) begin
      desc_o.vcase = VC_PRELAST;
    end else if (v_top) begin
      desc_o.vcase = VC_TOP;
    end
    desc_o.hcase     = col_last ? HC_RIGHT : (h_left ? HC_LEFT : HC_NORM);
    desc_o.emit      = (v_norm || v_top || v_pre || v_last) && (h_norm || col_last);
    desc_o.row_end   = col_last;
    desc_o.frame_end = col_last && v_last;
  end

  always_comb begin
    cfg_w_d = cfg_w_q;
    cfg_h_d = cfg_h_q;
    col_d   = col_q;
    row_d   = row_q;
    slot_d  = slot_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_OUT_WIDTH) begin
        cfg_w_d = cfg_data_i[WidthW-1:0];
        col_d   = '0;
        row_d   = '0;
        slot_d  = '0;
      end else if (cfg_idx_i == REG_OUT_HEIGHT) begin
        cfg_h_d = cfg_data_i[HeightW-1:0];
        col_d   = '0;
        row_d   = '0;
        slot_d  = '0;
      end
    end else if (accept) begin
      if (col_last) begin
        col_d = '0;
        if (row_last) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_q + RowW'(1);
          slot_d = (slot_q == SlotW'(LineRows - 1)) ? '0 : slot_q + SlotW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= WidthW'(320);
      cfg_h_q <= HeightW'(240);
      col_q   <= '0;
      row_q   <= '0;
      slot_q  <= '0;
    end else begin
      cfg_w_q <= cfg_w_d;
      cfg_h_q <= cfg_h_d;
      col_q   <= col_d;
      row_q   <= row_d;
      slot_q  <= slot_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bpr_queue.sv =====
// Short request queue between front and back.
`default_nettype none
module bpr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bpr_pkg::desc_t desc_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output bpr_pkg::desc_t      desc_o
);
  import bpr_pkg::*;

  desc_t              mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign desc_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bpr_back.sv =====
// Back end: line store banks, vertical taps, horizontal taps and output register.
`default_nettype none
module bpr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire bpr_pkg::desc_t q_desc_i,
  output logic                pop_o,
  bpr_out_if.source           out_o
);
  import bpr_pkg::*;

  logic [PixW-1:0]  rd_q [LineRows];
  desc_t            d1_q, d2_q;
  logic             v1_q, v2_q, ovalid_q;
  logic [VSumW-1:0] vsum_q, vsum_d;
  logic [VSumW-1:0] hist_q [3];
  logic [HSumW-1:0] hsum;
  logic [PixW-1:0]  pix_q;
  logic             row_end_q, frame_end_q;
  logic             adv;
  logic [VSumW-1:0] p0, p1, p2, p3, h0, h1, h2, vc;

  // Whole back end moves together; it holds only while the result waits.
  assign adv   = !ovalid_q || out_o.ready;
  assign pop_o = q_valid_i && adv;

  for (genvar b = 0; b < LineRows; b++) begin : g_bank
    logic [PixW-1:0] mem [RowSpan];
    always_ff @(posedge clk_i) begin
      if (pop_o) begin
        if (q_desc_i.slot == SlotW'(b)) begin
          mem[q_desc_i.col] <= q_desc_i.pixel;
        end
        rd_q[b] <= mem[q_desc_i.col];
      end
    end
  end

  always_comb begin
    p0 = VSumW'(d1_q.pixel);
    p1 = VSumW'(rd_q[prev_slot(d1_q.slot, SlotW'(1))]);
    p2 = VSumW'(rd_q[prev_slot(d1_q.slot, SlotW'(2))]);
    p3 = VSumW'(rd_q[prev_slot(d1_q.slot, SlotW'(3))]);
    unique case (d1_q.vcase)
      VC_NORM:    vsum_d = p0 + (p1 << 1) + p1 + (p2 << 1) + p2 + p3;
      VC_TOP:     vsum_d = p0 + (p1 << 2) + (p2 << 1) + p2;
      VC_PRELAST: vsum_d = (p0 << 1) + p0 + (p1 << 1) + p1 + p2 + p3;
      VC_LAST:    vsum_d = (p0 << 1) + p0 + (p1 << 1) + p1 + p2 + p3;
      default:    vsum_d = '0;
    endcase
  end

  always_comb begin
    vc = vsum_q;
    h0 = hist_q[0];
    h1 = hist_q[1];
    h2 = hist_q[2];
    unique case (d2_q.hcase)
      HC_NORM:  hsum = HSumW'(h2) + (HSumW'(h1) << 1) + HSumW'(h1)
                       + (HSumW'(h0) << 1) + HSumW'(h0) + HSumW'(vc);
      HC_LEFT:  hsum = (HSumW'(h0) << 2) + (HSumW'(h1) << 1) + HSumW'(h1) + HSumW'(vc);
      HC_RIGHT: hsum = (HSumW'(h1) << 1) + (HSumW'(h0) << 1) + HSumW'(h0)
                       + (HSumW'(vc) << 1) + HSumW'(vc);
      default:  hsum = '0;
    endcase
    hsum = hsum + HSumW'(32);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q   <= q_desc_i;
      d2_q   <= d1_q;
      vsum_q <= vsum_d;
      if (v2_q) begin
        hist_q[0]   <= vsum_q;
        hist_q[1]   <= hist_q[0];
        hist_q[2]   <= hist_q[1];
        pix_q       <= hsum[HSumW-1:6];
        row_end_q   <= d2_q.row_end;
        frame_end_q <= d2_q.frame_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else if (adv) begin
      v1_q     <= pop_o;
      v2_q     <= v1_q;
      ovalid_q <= v2_q && d2_q.emit;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.pixel_out = pix_q;
  assign out_o.row_end   = row_end_q;
  assign out_o.frame_end = frame_end_q;

endmodule
`default_nettype wire

// ===== hdl/bpr_checker.sv =====
// Port-level checker for the pyramid reducer, bound to the top level.
`default_nettype none
`include "binomial_pyramid_reduce_2x_macros.svh"
module bpr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] pixel_out,
  input wire logic       row_end,
  input wire logic       frame_end
);

  `BPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output request dropped")
  `BPR_ASSERT_NEXT(a_pix_hold, out_valid && !out_ready, $stable(pixel_out), "stalled pixel changed")
  `BPR_ASSERT_IMPL(a_frame_row, out_valid && frame_end, row_end, "frame end without row end")
  // Input can only back up after the output side held a result.
  `BPR_ASSERT_IMPL(a_backpressure, !in_ready, $past(out_valid && !out_ready),
                   "input stalled without output stall")

endmodule

bind binomial_pyramid_reduce_2x bpr_checker u_bpr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .pixel_out (out_o.pixel_out),
  .row_end   (out_o.row_end),
  .frame_end (out_o.frame_end)
);
`default_nettype wire
